// File: sv/hrlp_pkg.sv
// Shared types, codes and byte helpers for the HTTP request line parser.
// No dependencies; used by http_request_line_parser_core.
`default_nettype none

package hrlp_pkg;

  // Default width of the name and query length counters.
  localparam int unsigned COUNT_WIDTH_DEF = 12;
  // Width and reset value of the name limit register.
  localparam int unsigned LIMIT_WIDTH = 12;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 12'd1023;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_GAP    = 3'd1,
    PH_PATH   = 3'd2,
    PH_PROTO  = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    PD_NONE  = 2'd0,
    PD_PCT   = 2'd1,
    PD_DIGIT = 2'd2
  } pend_e;

  typedef enum logic [1:0] {
    SL_NONE = 2'd0,
    SL_OK   = 2'd1,
    SL_BAD  = 2'd2
  } slash_e;

  typedef enum logic [1:0] {
    K_NAME    = 2'd0,
    K_QUERY   = 2'd1,
    K_VERDICT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    V_OK          = 3'd0,
    V_BAD_REQUEST = 3'd1,
    V_BAD_METHOD  = 3'd2,
    V_BAD_NAME    = 3'd3,
    V_BAD_QUERY   = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_request;
  } req_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [2:0] verdict;
    logic       last_of_run;
  } rsp_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= "0" && b <= "9") begin
      v = b - "0";
    end else if (b >= "a" && b <= "f") begin
      v = b - "a" + 8'd10;
    end else if (b >= "A" && b <= "F") begin
      v = b - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  // Expected upper-case method character at each match position.
  function automatic logic [7:0] get_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = "G";
      2'd1:    c = "E";
      2'd2:    c = "T";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/http_request_line_parser_core.sv
// HTTP request line parser core: method check, path split and percent decoding.
// Depends on hrlp_pkg for the request and result types and the code enums.
//
// Usage: raw request bytes enter on the in channel (valid/ready), one request
// per byte; start_of_request set on a byte clears the parser before that byte
// is taken. Results leave on the out channel (valid/ready): decoded name bytes
// after the leading '/', raw query bytes, and one verdict when CR or LF ends
// the line. Bytes after the line end give nothing until the next start flag.
// Each request gives zero to three results; last_of_run marks its final one.
//
// Timing: a request is captured in an input register, then decoded into a
// three-entry result buffer that drains one result per cycle while the
// receiver is ready. A request's first result is valid once it has passed the
// input register and been decoded into the buffer. A request giving at most
// one result sustains one request per cycle while the receiver is ready; one
// that flushes a malformed escape gives two or three results, and the next
// request waits for the buffer to drain; the drain port is the limiting resource.
//
// Reset clears the parser to the method phase, empties both registers and sets
// name_limit to 1023. When the receiver stalls, the buffer holds its results
// and one more request may wait in the input register; in_ready_o then drops.
// The user must write name_limit through cfg_we_i only while the block is idle; the block does not enforce it.
`default_nettype none

module http_request_line_parser_core #(
  parameter int unsigned COUNT_WIDTH = hrlp_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire hrlp_pkg::req_t                     in_req_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output hrlp_pkg::rsp_t                          out_rsp_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [hrlp_pkg::LIMIT_WIDTH-1:0]   cfg_wdata_i
);

  // Compare width wide enough for both the counters and the limit.
  localparam int unsigned CmpWidth = (COUNT_WIDTH > hrlp_pkg::LIMIT_WIDTH) ?
                                     COUNT_WIDTH : hrlp_pkg::LIMIT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    hrlp_pkg::phase_e    phase;
    logic [1:0]          mpos;
    logic                mmis;
    hrlp_pkg::pend_e     pend;
    logic [7:0]          held;
    hrlp_pkg::slash_e    slash;
    logic                in_query;
    logic [COUNT_WIDTH-1:0] ncnt;
    logic [COUNT_WIDTH-1:0] qcnt;
    logic                name_ended;
  } st_t;

  // Parser state together with the results produced so far for one request.
  typedef struct packed {
    st_t                    st;
    logic [1:0]             n;
    hrlp_pkg::rsp_t [2:0]   em;
  } work_t;

  localparam st_t StReset = '{
    phase:      hrlp_pkg::PH_METHOD,
    mpos:       2'd0,
    mmis:       1'b0,
    pend:       hrlp_pkg::PD_NONE,
    held:       8'd0,
    slash:      hrlp_pkg::SL_NONE,
    in_query:   1'b0,
    ncnt:       '0,
    qcnt:       '0,
    name_ended: 1'b0
  };

  function automatic logic method_ok(input st_t s);
    return !s.mmis && (s.mpos == 2'd3);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c != CountMax) ? c + 1'b1 : c;
  endfunction

  function automatic logic too_long(input logic [COUNT_WIDTH-1:0] c,
                                    input logic [hrlp_pkg::LIMIT_WIDTH-1:0] lim);
    logic [CmpWidth-1:0] cw;
    logic [CmpWidth-1:0] lw;
    cw = CmpWidth'(c);
    lw = CmpWidth'(lim);
    return (cw >= lw) || (c == CountMax);
  endfunction

  function automatic work_t push(input work_t w, input hrlp_pkg::kind_e k,
                                 input logic [7:0] b, input hrlp_pkg::verdict_e v);
    work_t r;
    r = w;
    if (r.n != 2'd3) begin
      r.em[r.n] = '{result_kind: k, out_byte: b, verdict: v, last_of_run: 1'b0};
      r.n = r.n + 2'd1;
    end
    return r;
  endfunction

  // One decoded name byte: the first one must be the leading slash, which is
  // swallowed; after a bad first byte nothing more is counted or emitted.
  function automatic work_t name_out(input work_t w, input logic [7:0] v);
    work_t r;
    r = w;
    if (r.st.slash == hrlp_pkg::SL_NONE) begin
      r.st.slash = (v == "/") ? hrlp_pkg::SL_OK : hrlp_pkg::SL_BAD;
    end else if (r.st.slash == hrlp_pkg::SL_OK) begin
      r.st.ncnt = sat_inc(r.st.ncnt);
      if (method_ok(r.st)) begin
        r = push(r, hrlp_pkg::K_NAME, v, hrlp_pkg::V_OK);
      end
    end
    return r;
  endfunction

  // A pending escape that did not complete is passed through as plain bytes.
  function automatic work_t flush(input work_t w);
    work_t r;
    r = w;
    if (r.st.pend == hrlp_pkg::PD_PCT) begin
      r = name_out(r, "%");
    end else if (r.st.pend == hrlp_pkg::PD_DIGIT) begin
      r = name_out(r, "%");
      r = name_out(r, r.st.held);
    end
    r.st.pend = hrlp_pkg::PD_NONE;
    return r;
  endfunction

  function automatic work_t path_byte(input work_t w, input logic [7:0] b);
    work_t r;
    logic  taken;
    r = w;
    taken = 1'b0;
    if (r.st.in_query) begin
      r.st.qcnt = sat_inc(r.st.qcnt);
      if (method_ok(r.st)) begin
        r = push(r, hrlp_pkg::K_QUERY, b, hrlp_pkg::V_OK);
      end
      taken = 1'b1;
    end else if (r.st.pend == hrlp_pkg::PD_PCT) begin
      if (hrlp_pkg::is_hex(b)) begin
        r.st.held = b;
        r.st.pend = hrlp_pkg::PD_DIGIT;
        taken = 1'b1;
      end else begin
        r = flush(r);
      end
    end else if (r.st.pend == hrlp_pkg::PD_DIGIT) begin
      if (hrlp_pkg::is_hex(b)) begin
        r = name_out(r, {hrlp_pkg::hex_val(r.st.held), hrlp_pkg::hex_val(b)});
        r.st.pend = hrlp_pkg::PD_NONE;
        taken = 1'b1;
      end else begin
        r = flush(r);
      end
    end
    // A byte that broke an escape is scanned again as an ordinary byte.
    if (!taken) begin
      if (b == "%") begin
        r.st.pend = hrlp_pkg::PD_PCT;
      end else if (b == "?") begin
        r.st.in_query = 1'b1;
        r.st.name_ended = 1'b1;
      end else begin
        r = name_out(r, b);
      end
    end
    return r;
  endfunction

  function automatic hrlp_pkg::verdict_e final_verdict(input st_t s,
      input logic [hrlp_pkg::LIMIT_WIDTH-1:0] lim);
    hrlp_pkg::verdict_e v;
    priority if (s.phase != hrlp_pkg::PH_PROTO) begin
      v = hrlp_pkg::V_BAD_REQUEST;
    end else if (!method_ok(s)) begin
      v = hrlp_pkg::V_BAD_METHOD;
    end else if (s.slash != hrlp_pkg::SL_OK || too_long(s.ncnt, lim)) begin
      v = hrlp_pkg::V_BAD_NAME;
    end else if (too_long(s.qcnt, lim)) begin
      v = hrlp_pkg::V_BAD_QUERY;
    end else begin
      v = hrlp_pkg::V_OK;
    end
    return v;
  endfunction

  // Registers.
  logic [hrlp_pkg::LIMIT_WIDTH-1:0] name_limit_q;
  st_t                              state_q, state_d;
  logic                             in_valid_q;
  hrlp_pkg::req_t                   req_q;
  hrlp_pkg::rsp_t [2:0]             res_q, res_d;
  logic [1:0]                       left_q;
  logic [1:0]                       left_d;
  logic [1:0]                       rd_q;

  logic  process;
  logic  drain;
  work_t w;
  logic  sep;
  logic  eol;
  logic [7:0] b;
  logic [7:0] up;

  assign drain       = out_valid_o && out_ready_i;
  // The buffered request is decoded once the result buffer is free by the
  // next edge: empty, or holding one result that is being taken now.
  assign process     = in_valid_q && ((left_q == 2'd0) || ((left_q == 2'd1) && out_ready_i));
  assign in_ready_o  = !in_valid_q || process;
  assign out_valid_o = (left_q != 2'd0);
  assign out_rsp_o   = res_q[rd_q];

  always_comb begin
    w     = '0;
    w.st  = state_q;
    b     = req_q.data_byte;
    up    = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    sep   = (b == " ") || (b == "\t");
    eol   = (b == 8'h0a) || (b == 8'h0d);
    if (req_q.start_of_request) begin
      w.st = StReset;
    end
    if (w.st.phase != hrlp_pkg::PH_DONE) begin
      if (eol) begin
        if (w.st.phase == hrlp_pkg::PH_PATH && !w.st.name_ended) begin
          w = flush(w);
        end
        w = push(w, hrlp_pkg::K_VERDICT, 8'd0, final_verdict(w.st, name_limit_q));
        w.st.phase = hrlp_pkg::PH_DONE;
      end else begin
        unique case (w.st.phase)
          hrlp_pkg::PH_METHOD: begin
            if (sep) begin
              w.st.phase = hrlp_pkg::PH_GAP;
            end else if (w.st.mpos != 2'd3 && up == hrlp_pkg::get_char(w.st.mpos)) begin
              w.st.mpos = w.st.mpos + 2'd1;
            end else begin
              w.st.mmis = 1'b1;
            end
          end
          hrlp_pkg::PH_GAP: begin
            if (!sep) begin
              w.st.phase = hrlp_pkg::PH_PATH;
              w = path_byte(w, b);
            end
          end
          hrlp_pkg::PH_PATH: begin
            if (sep) begin
              if (!w.st.name_ended) begin
                w = flush(w);
              end
              w.st.name_ended = 1'b1;
              w.st.phase = hrlp_pkg::PH_PROTO;
            end else begin
              w = path_byte(w, b);
            end
          end
          default: begin
            // Protocol content is not checked.
          end
        endcase
      end
    end
    if (w.n != 2'd0) begin
      w.em[w.n - 2'd1].last_of_run = 1'b1;
    end
    state_d = w.st;
    res_d   = w.em;
    left_d  = w.n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q <= hrlp_pkg::LIMIT_RESET;
      state_q      <= StReset;
      in_valid_q   <= 1'b0;
      left_q       <= 2'd0;
      rd_q         <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        name_limit_q <= cfg_wdata_i;
      end
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (process) begin
        in_valid_q <= 1'b0;
      end
      if (process) begin
        state_q <= state_d;
        left_q  <= left_d;
        rd_q    <= 2'd0;
      end else if (drain) begin
        left_q <= left_q - 2'd1;
        rd_q   <= rd_q + 2'd1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (process) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_http_request_line_parser_core.sv
// Self-checking testbench for http_request_line_parser_core.
// Depends on hrlp_pkg and the core; drives directed and random valid/ready traffic
// and checks every result against a predictor kept in this file or the directed table.
`default_nettype none

module tb_http_request_line_parser_core;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 10;
  // The core shows a result once the request has passed its input register and result
  // buffer; the settle time also covers a request that gives no result but is still in flight.
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 200000;
  localparam int MAX_GAP        = 13;
  localparam int ITEMS_PER_PASS = 50;
  localparam int N_PASSES       = 6;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_TU     = 30000000;

  localparam logic [hrlp_pkg::LIMIT_WIDTH-1:0]     LIMIT_MAX = '1;
  localparam logic [hrlp_pkg::COUNT_WIDTH_DEF-1:0] COUNT_SAT = '1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [23:0] GET_WORD = "GET";

  // Shape of one random request line.
  typedef enum int {
    LINE_GOOD,
    LINE_CUT,
    LINE_NOISE
  } line_mode_e;

  // One row of the directed table: the request, and where the result can be
  // read off directly, the single result that it must give.
  typedef struct packed {
    hrlp_pkg::req_t req;
    bit             typed;
    hrlp_pkg::rsp_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  hrlp_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  hrlp_pkg::rsp_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic [hrlp_pkg::LIMIT_WIDTH-1:0] cfg_wdata_i = '0;

  http_request_line_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parser predictor. It mirrors the architectural state of the core and, for
  // each accepted request, leaves the results that request causes in step_q.
  // ---------------------------------------------------------------------------
  logic [hrlp_pkg::LIMIT_WIDTH-1:0]     limit_q;
  hrlp_pkg::phase_e                     p_phase;
  logic [1:0]                           match_pos;
  bit                                   method_bad;
  hrlp_pkg::pend_e                      p_pend;
  logic [7:0]                           p_held;
  hrlp_pkg::slash_e                     p_slash;
  bit                                   p_in_query;
  logic [hrlp_pkg::COUNT_WIDTH_DEF-1:0] name_cnt;
  logic [hrlp_pkg::COUNT_WIDTH_DEF-1:0] query_cnt;
  bit                                   p_name_done;

  hrlp_pkg::rsp_t step_q[$];
  // Results still owed by the core, oldest first.
  hrlp_pkg::rsp_t expected_q[$];

  int fail_count = 0;
  int sent_reqs = 0;
  int parsed_reqs = 0;
  int checked_results = 0;
  int limit_settings = 1;
  int tx_calm = 0;
  int rx_calm = 0;
  int rx_hold = 0;

  logic [7:0] line_q[$];
  dir_row_t   dir_tab[$];

  // The limit register survives a start flag; everything else is cleared.
  task automatic clear_parser();
    p_phase     = hrlp_pkg::PH_METHOD;
    match_pos   = 2'd0;
    method_bad  = 1'b0;
    p_pend      = hrlp_pkg::PD_NONE;
    p_held      = 8'h00;
    p_slash     = hrlp_pkg::SL_NONE;
    p_in_query  = 1'b0;
    name_cnt    = '0;
    query_cnt   = '0;
    p_name_done = 1'b0;
  endtask

  // Value of a hex digit character, or -1 for anything else.
  function automatic int hex_nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic bit method_is_get();
    return !method_bad && match_pos == 2'd3;
  endfunction

  // A saturated count is rejected whatever the limit is.
  function automatic bit over_limit(logic [hrlp_pkg::COUNT_WIDTH_DEF-1:0] n);
    return n >= limit_q || n == COUNT_SAT;
  endfunction

  task automatic add_result(hrlp_pkg::kind_e k, logic [7:0] b, hrlp_pkg::verdict_e v);
    hrlp_pkg::rsp_t r;
    r.result_kind = k;
    r.out_byte    = b;
    r.verdict     = v;
    r.last_of_run = 1'b0;
    if (step_q.size() < 3) step_q.push_back(r);
  endtask

  // A decoded name byte. The first one only decides whether the name has its
  // leading slash; a name without it is never emitted.
  task automatic name_emit(logic [7:0] v);
    if (p_slash == hrlp_pkg::SL_NONE) begin
      p_slash = (v == CH_SLASH) ? hrlp_pkg::SL_OK : hrlp_pkg::SL_BAD;
      return;
    end
    if (p_slash != hrlp_pkg::SL_OK) return;
    if (name_cnt != COUNT_SAT) name_cnt++;
    if (method_is_get()) add_result(hrlp_pkg::K_NAME, v, hrlp_pkg::V_OK);
  endtask

  // A broken escape passes its percent sign and any held digit through.
  task automatic flush_escape();
    if (p_pend == hrlp_pkg::PD_PCT) begin
      name_emit(CH_PCT);
    end else if (p_pend == hrlp_pkg::PD_DIGIT) begin
      name_emit(CH_PCT);
      name_emit(p_held);
    end
    p_pend = hrlp_pkg::PD_NONE;
  endtask

  task automatic path_step(logic [7:0] b);
    int nib;
    logic [7:0] dec;
    nib = hex_nibble(b);
    if (p_in_query) begin
      if (query_cnt != COUNT_SAT) query_cnt++;
      if (method_is_get()) add_result(hrlp_pkg::K_QUERY, b, hrlp_pkg::V_OK);
      return;
    end
    if (p_pend == hrlp_pkg::PD_PCT) begin
      if (nib >= 0) begin
        p_held = b;
        p_pend = hrlp_pkg::PD_DIGIT;
        return;
      end
      flush_escape();
    end else if (p_pend == hrlp_pkg::PD_DIGIT) begin
      if (nib >= 0) begin
        dec = 8'(hex_nibble(p_held) * 16 + nib);
        name_emit(dec);
        p_pend = hrlp_pkg::PD_NONE;
        return;
      end
      flush_escape();
    end
    // The byte that broke an escape is scanned again as a fresh byte.
    if (b == CH_PCT) begin
      p_pend = hrlp_pkg::PD_PCT;
    end else if (b == CH_QMARK) begin
      p_in_query  = 1'b1;
      p_name_done = 1'b1;
    end else begin
      name_emit(b);
    end
  endtask

  // Verdict priority: incomplete line, method, name, query.
  function automatic hrlp_pkg::verdict_e line_verdict();
    if (p_phase != hrlp_pkg::PH_PROTO) return hrlp_pkg::V_BAD_REQUEST;
    if (!method_is_get()) return hrlp_pkg::V_BAD_METHOD;
    if (p_slash != hrlp_pkg::SL_OK || over_limit(name_cnt)) return hrlp_pkg::V_BAD_NAME;
    if (over_limit(query_cnt)) return hrlp_pkg::V_BAD_QUERY;
    return hrlp_pkg::V_OK;
  endfunction

  task automatic predict_request(hrlp_pkg::req_t r, output bit ignored);
    logic [7:0] b;
    logic [7:0] up;
    bit sep;
    bit eol;
    hrlp_pkg::rsp_t tail;
    b = r.data_byte;
    step_q.delete();
    if (r.start_of_request) clear_parser();
    ignored = (p_phase == hrlp_pkg::PH_DONE);
    if (ignored) return;
    sep = (b == CH_SP || b == CH_TAB);
    eol = (b == CH_CR || b == CH_LF);
    if (eol) begin
      if (p_phase == hrlp_pkg::PH_PATH && !p_name_done) flush_escape();
      add_result(hrlp_pkg::K_VERDICT, 8'h00, line_verdict());
      p_phase = hrlp_pkg::PH_DONE;
    end else begin
      unique case (p_phase)
        hrlp_pkg::PH_METHOD: begin
          if (sep) begin
            p_phase = hrlp_pkg::PH_GAP;
          end else begin
            up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
            if (match_pos != 2'd3 && up == GET_WORD[23 - 8 * match_pos -: 8]) begin
              match_pos++;
            end else begin
              method_bad = 1'b1;
            end
          end
        end
        hrlp_pkg::PH_GAP: begin
          if (!sep) begin
            p_phase = hrlp_pkg::PH_PATH;
            path_step(b);
          end
        end
        hrlp_pkg::PH_PATH: begin
          if (sep) begin
            if (!p_name_done) flush_escape();
            p_name_done = 1'b1;
            p_phase     = hrlp_pkg::PH_PROTO;
          end else begin
            path_step(b);
          end
        end
        default: ;
      endcase
    end
    if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.last_of_run = 1'b1;
      step_q.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle draws. Each side may idle between items for a random gap, with occasional
  // runs where it does not idle at all.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(bit rx_side);
    int run_len;
    if (rx_side && rx_calm > 0) begin
      rx_calm--;
      return 0;
    end
    if (!rx_side && tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run_len = $urandom_range(8, 40);
      if (rx_side) rx_calm = run_len;
      else tx_calm = run_len;
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Request side. The caller is always at a rising edge. Valid is only lowered
  // when a gap is drawn, so back-to-back requests keep it high.
  // ---------------------------------------------------------------------------
  task automatic send_request(hrlp_pkg::req_t r, bit typed, hrlp_pkg::rsp_t want);
    bit ignored;
    int gap;
    gap = pick_gap(1'b0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(r, ignored);
    if (typed) begin
      expected_q.push_back(want);
    end else begin
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    end
    sent_reqs++;
    if (!ignored) parsed_reqs++;
  endtask

  // The register is only written with no result outstanding and the core
  // settled, so the limit change cannot race a verdict.
  task automatic wait_idle();
    for (int w = 0; w < DRAIN_LIMIT && expected_q.size() != 0; w++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [hrlp_pkg::LIMIT_WIDTH-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    limit_q = v;
    cfg_we_i <= 1'b0;
    limit_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table helpers.
  // ---------------------------------------------------------------------------
  task automatic add_row(logic [7:0] b, bit sor, bit typed, hrlp_pkg::verdict_e v);
    dir_row_t row;
    row.req.data_byte        = b;
    row.req.start_of_request = sor;
    row.typed                = typed;
    row.want.result_kind     = hrlp_pkg::K_VERDICT;
    row.want.out_byte        = 8'h00;
    row.want.verdict         = v;
    row.want.last_of_run     = 1'b1;
    dir_tab.push_back(row);
  endtask

  task automatic add_text(string s, bit sor);
    for (int i = 0; i < s.len(); i++) add_row(s[i], sor && i == 0, 1'b0, hrlp_pkg::V_OK);
  endtask

  // ---------------------------------------------------------------------------
  // Random request lines.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF ||
               c == CH_PCT || c == CH_QMARK);
    return c;
  endfunction

  // Anything the query or the protocol may hold: all but separators and EOL.
  function automatic logic [7:0] free_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  // Byte that breaks an escape: another percent, a question mark, or any
  // plain non-hex byte.
  function automatic logic [7:0] escape_breaker();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: return CH_PCT;
      1: return CH_QMARK;
      default: begin
        do begin
          c = plain_char();
        end while (hex_nibble(c) >= 0);
        return c;
      end
    endcase
  endfunction

  function automatic logic [7:0] sep_char();
    return $urandom_range(0, 1) ? CH_SP : CH_TAB;
  endfunction

  function automatic logic [7:0] eol_char();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  task automatic push_name_token();
    case ($urandom_range(0, 11))
      0, 1: begin
        // Valid escape; now and then an encoded slash.
        line_q.push_back(CH_PCT);
        if ($urandom_range(0, 3) == 0) begin
          line_q.push_back("2");
          line_q.push_back($urandom_range(0, 1) ? "F" : "f");
        end else begin
          line_q.push_back(hex_char());
          line_q.push_back(hex_char());
        end
      end
      2: begin
        line_q.push_back(CH_PCT);
        line_q.push_back(escape_breaker());
      end
      3: begin
        line_q.push_back(CH_PCT);
        line_q.push_back(hex_char());
        line_q.push_back(escape_breaker());
      end
      4: begin
        line_q.push_back(CH_PCT);
        line_q.push_back("0");
        line_q.push_back("0");
      end
      5: begin
        // Escape left open; whatever follows decides its fate.
        line_q.push_back(CH_PCT);
        if ($urandom_range(0, 1)) line_q.push_back(hex_char());
      end
      default: line_q.push_back(plain_char());
    endcase
  endtask

  task automatic build_line(line_mode_e mode);
    int cut;
    logic [7:0] c;
    line_q.delete();
    if (mode == LINE_NOISE) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 6) != 0) begin
      for (int i = 0; i < 3; i++) begin
        c = GET_WORD[23 - 8 * i -: 8];
        line_q.push_back($urandom_range(0, 1) ? (c | 8'h20) : c);
      end
    end else begin
      repeat ($urandom_range(0, 4)) line_q.push_back(free_char());
    end
    repeat ($urandom_range(1, 2)) line_q.push_back(sep_char());
    case ($urandom_range(0, 9))
      8: line_q.push_back(plain_char());
      9: ;
      default: line_q.push_back(CH_SLASH);
    endcase
    repeat ($urandom_range(0, 5)) push_name_token();
    if ($urandom_range(0, 2) == 0) begin
      line_q.push_back(CH_QMARK);
      repeat ($urandom_range(0, 6)) line_q.push_back(free_char());
    end
    repeat ($urandom_range(1, 2)) line_q.push_back(sep_char());
    repeat ($urandom_range(0, 3)) line_q.push_back(free_char());
    line_q.push_back(eol_char());
    if (mode == LINE_CUT) begin
      cut = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
      line_q.push_back(eol_char());
    end
    // Trailing bytes after the line end must be swallowed silently.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Noise lines also raise the start flag in the middle of a line.
  task automatic send_line(bit noisy);
    hrlp_pkg::req_t r;
    hrlp_pkg::rsp_t none;
    none = '0;
    foreach (line_q[i]) begin
      r.data_byte        = line_q[i];
      r.start_of_request = (i == 0) || (noisy && $urandom_range(0, 7) == 0);
      send_request(r, 1'b0, none);
    end
  endtask

  function automatic logic [hrlp_pkg::LIMIT_WIDTH-1:0] limit_for(int pass);
    case (pass)
      1: return '0;
      2: return LIMIT_MAX;
      3: return hrlp_pkg::LIMIT_WIDTH'(1);
      4: return hrlp_pkg::LIMIT_WIDTH'($urandom_range(2, 12));
      default: return hrlp_pkg::LIMIT_WIDTH'($urandom_range(1, LIMIT_MAX));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and an in-order check of every result.
  // ---------------------------------------------------------------------------
  task automatic check_result(hrlp_pkg::rsp_t got);
    hrlp_pkg::rsp_t want;
    checked_results++;
    if (expected_q.size() == 0) begin
      note_failure($sformatf("unexpected result kind=%0d byte=%02h verdict=%0d last=%0b",
                             got.result_kind, got.out_byte, got.verdict, got.last_of_run));
      return;
    end
    want = expected_q.pop_front();
    if (got.result_kind !== want.result_kind || got.out_byte !== want.out_byte ||
        got.verdict !== want.verdict || got.last_of_run !== want.last_of_run) begin
      note_failure($sformatf({"result %0d: expected kind=%0d byte=%02h verdict=%0d last=%0b, ",
                              "got kind=%0d byte=%02h verdict=%0d last=%0b"},
                             checked_results, want.result_kind, want.out_byte, want.verdict,
                             want.last_of_run, got.result_kind, got.out_byte, got.verdict,
                             got.last_of_run));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_result(out_rsp_o);
        rx_hold = pick_gap(1'b1);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
    end
    out_ready_i <= (rx_hold == 0);
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random passes under different limits.
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    int pick;
    line_mode_e mode;
    clear_parser();
    limit_q = hrlp_pkg::LIMIT_RESET;

    // All-ones byte opens a line and spoils the method; the line then ends in
    // the method phase, and a zero byte after the end is ignored.
    add_row(8'hFF, 1'b1, 1'b0, hrlp_pkg::V_OK);
    add_row(CH_CR, 1'b0, 1'b1, hrlp_pkg::V_BAD_REQUEST);
    add_row(8'h00, 1'b0, 1'b0, hrlp_pkg::V_OK);
    // Mixed-case GET, tab separator, a decoded zero byte, a broken escape that
    // flushes two bytes before the byte that broke it, and a one-byte query.
    add_text("gEt\t/%00%4z?% ", 1'b1);
    add_row(CH_LF, 1'b0, 1'b1, hrlp_pkg::V_OK);
    // Line ends in the path with an escape half done: the held bytes are
    // flushed ahead of the bad request verdict.
    add_text("GET /%4", 1'b1);
    add_row(CH_LF, 1'b0, 1'b0, hrlp_pkg::V_OK);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
    in_valid_i <= 1'b0;

    // The first pass runs on the reset limit; each later one rewrites it.
    for (int pass = 0; pass < N_PASSES; pass++) begin
      if (pass > 0) begin
        wait_idle();
        write_limit(limit_for(pass));
      end
      target = sent_reqs + ITEMS_PER_PASS;
      while (sent_reqs < target) begin
        pick = $urandom_range(0, 19);
        mode = (pick < 14) ? LINE_GOOD : (pick < 17) ? LINE_CUT : LINE_NOISE;
        build_line(mode);
        send_line(mode == LINE_NOISE);
      end
      in_valid_i <= 1'b0;
    end

    wait_idle();
    if (expected_q.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", expected_q.size()));
    end

    $display("Run: %0d requests sent, %0d parsed, %0d results checked, %0d limit settings.",
             sent_reqs, parsed_reqs, checked_results, limit_settings);
    $display("Mismatches: %0d.", fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TU);
    $display("Timeout: run did not finish.");
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/hrlp_pkg.sv
sv/http_request_line_parser_core.sv
tb/tb_http_request_line_parser_core.sv
